@@ rtl/core/pss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

    // Store size and the widths that follow from it.
    localparam int MAX_PARTICLES = 64;
    localparam int SLOT_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_REST_DISTANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING       = 8'd1;
    localparam logic [11:0] REST_DISTANCE_RESET = 12'd250;
    localparam logic [15:0] DAMPING_RESET       = 16'd58982;

    // Command codes.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Input beat.
    typedef struct packed {
        logic               command;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic        [15:0] new_mass;
    } pss_in_t;

    // Result beat.
    typedef struct packed {
        logic [5:0]         slot;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               dropped;
        logic               last;
    } pss_out_t;

endpackage

`default_nettype wire

@@ rtl/core/pairwise_spring_particle_step.sv @@
// Add beat: the result is offered in the cycle after the input beat is accepted.
// Step beat: each ordered particle pair goes through the bit-serial square root
// and divider; after all velocities are updated, one result beat per particle
// follows in slot order. One item is worked at a time.
// Reset (aresetn low, synchronous) empties the store and restores the registers.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_spring_particle_step (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire pss_pkg::pss_in_t               s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output pss_pkg::pss_out_t                   m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [15:0]                    cfg_data
);
    import pss_pkg::*;

    typedef enum logic [24:0] {
        ST_IDLE   = 25'h0000001,
        ST_A_RD   = 25'h0000002,
        ST_A_LD   = 25'h0000004,
        ST_B_CHK  = 25'h0000008,
        ST_B_LD   = 25'h0000010,
        ST_SQ_X   = 25'h0000020,
        ST_SQ_Y   = 25'h0000040,
        ST_SQ_ADD = 25'h0000080,
        ST_SQ_GO  = 25'h0000100,
        ST_SQ_WT  = 25'h0000200,
        ST_FRC    = 25'h0000400,
        ST_DV_GO  = 25'h0000800,
        ST_DV_WT  = 25'h0001000,
        ST_F_X    = 25'h0002000,
        ST_F_Y    = 25'h0004000,
        ST_F_ACC  = 25'h0008000,
        ST_V_RD   = 25'h0010000,
        ST_V_M1   = 25'h0020000,
        ST_V_M2   = 25'h0040000,
        ST_V_M3   = 25'h0080000,
        ST_V_M4   = 25'h0100000,
        ST_V_M5   = 25'h0200000,
        ST_P_RD   = 25'h0400000,
        ST_P_WR   = 25'h0800000,
        ST_OUT    = 25'h1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [11:0]      rest_reg;
    logic [15:0]      damp_reg;
    logic             m_valid_reg;
    pss_out_t         m_data_reg;

    // Particle store.
    logic signed [31:0] mem_x  [MAX_PARTICLES];
    logic signed [31:0] mem_y  [MAX_PARTICLES];
    logic        [15:0] mem_m  [MAX_PARTICLES];
    logic signed [31:0] mem_vx [MAX_PARTICLES];
    logic signed [31:0] mem_vy [MAX_PARTICLES];
    logic signed [31:0] rd_x_reg, rd_y_reg, rd_vx_reg, rd_vy_reg;
    logic        [15:0] rd_m_reg;
    logic [SLOT_W-1:0]  rd_addr, wr_addr;
    logic               we_pos, we_m, we_vx, we_vy;
    logic signed [31:0] wd_x, wd_y, wd_vx, wd_vy;

    // Loop counters and working registers.
    logic [CNT_W-1:0]   a_reg, b_reg;
    logic signed [31:0] xa_reg, ya_reg;
    logic        [15:0] ma_reg, mb_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic        [62:0] sq_reg;
    logic        [31:0] d_reg;
    logic signed [31:0] force_reg;
    logic signed [51:0] ax_reg, ay_reg;
    logic signed [49:0] t_reg;
    logic signed [65:0] p_reg;
    logic signed [32:0] op_a, op_b;

    logic               sqrt_start, sqrt_done, div_start, div_done;
    logic        [31:0] sqrt_root;
    logic signed [31:0] div_quot;

    logic               in_fire, out_fire, full, b_end, b_self, a_last;
    logic signed [32:0] diff_x, diff_y;
    logic signed [31:0] dxs, dys, axc, ayc, new_vel, new_x, new_y;
    logic signed [49:0] t_sum;
    logic signed [51:0] term;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] satdiff(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -33'sd2147483647) begin
            r = 32'sh80000001;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign full     = (cnt_reg == CNT_W'(MAX_PARTICLES));
    assign b_end    = (b_reg == cnt_reg);
    assign b_self   = (b_reg == a_reg);
    assign a_last   = (a_reg + CNT_W'(1) == cnt_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Offsets to the other particle, clamped symmetric.
    assign diff_x = 33'(rd_x_reg) - 33'(xa_reg);
    assign diff_y = 33'(rd_y_reg) - 33'(ya_reg);
    assign dxs    = satdiff(diff_x);
    assign dys    = satdiff(diff_y);

    // Floor of the product over 65536, as one force term.
    assign term = 52'(signed'(p_reg[65:16]));

    assign axc   = sat32(66'(ax_reg));
    assign ayc   = sat32(66'(ay_reg));
    assign t_sum = t_reg + p_reg[49:0];
    assign new_vel = sat32(66'(t_sum >>> 16));
    assign new_x = sat32(66'(33'(rd_x_reg) + 33'(rd_vx_reg)));
    assign new_y = sat32(66'(33'(rd_y_reg) + 33'(rd_vy_reg)));

    // Shared multiplier operand selection.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_SQ_X: begin
                op_a = 33'(dx_reg);
                op_b = 33'(dx_reg);
            end
            ST_SQ_Y: begin
                op_a = 33'(dy_reg);
                op_b = 33'(dy_reg);
            end
            ST_FRC: begin
                op_a = signed'({1'b0, d_reg}) - signed'({5'b0, rest_reg, 16'b0});
                op_b = signed'({17'b0, mb_reg});
            end
            ST_F_X: begin
                op_a = 33'(force_reg);
                op_b = 33'(dx_reg);
            end
            ST_F_Y: begin
                op_a = 33'(force_reg);
                op_b = 33'(dy_reg);
            end
            ST_V_M1: begin
                op_a = signed'({17'b0, damp_reg});
                op_b = 33'(rd_vx_reg);
            end
            ST_V_M2: begin
                op_a = 33'(axc);
                op_b = signed'({17'b0, ma_reg});
            end
            ST_V_M3: begin
                op_a = signed'({17'b0, damp_reg});
                op_b = 33'(rd_vy_reg);
            end
            ST_V_M4: begin
                op_a = 33'(ayc);
                op_b = signed'({17'b0, ma_reg});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg <= op_a * op_b;
    end

    // Store read and write ports.
    assign rd_addr = (state_reg == ST_B_CHK) ? b_reg[SLOT_W-1:0] : a_reg[SLOT_W-1:0];
    assign wr_addr = (state_reg == ST_IDLE) ? cnt_reg[SLOT_W-1:0] : a_reg[SLOT_W-1:0];
    assign we_m    = (state_reg == ST_IDLE) && in_fire && s_data.command == CMD_ADD && !full;
    assign we_pos  = we_m || (state_reg == ST_P_WR);
    assign we_vx   = we_m || (state_reg == ST_V_M3);
    assign we_vy   = we_m || (state_reg == ST_V_M5);
    assign wd_x    = (state_reg == ST_IDLE) ? s_data.new_x : new_x;
    assign wd_y    = (state_reg == ST_IDLE) ? s_data.new_y : new_y;
    assign wd_vx   = (state_reg == ST_IDLE) ? 32'sd0 : new_vel;
    assign wd_vy   = (state_reg == ST_IDLE) ? 32'sd0 : new_vel;

    always_ff @(posedge aclk) begin
        if (we_pos) begin
            mem_x[wr_addr] <= wd_x;
            mem_y[wr_addr] <= wd_y;
        end
        if (we_m) begin
            mem_m[wr_addr] <= s_data.new_mass;
        end
        if (we_vx) begin
            mem_vx[wr_addr] <= wd_vx;
        end
        if (we_vy) begin
            mem_vy[wr_addr] <= wd_vy;
        end
        rd_x_reg  <= mem_x[rd_addr];
        rd_y_reg  <= mem_y[rd_addr];
        rd_m_reg  <= mem_m[rd_addr];
        rd_vx_reg <= mem_vx[rd_addr];
        rd_vy_reg <= mem_vy[rd_addr];
    end

    assign sqrt_start = (state_reg == ST_SQ_GO);
    assign div_start  = (state_reg == ST_DV_GO);

    pss_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({1'b0, sq_reg}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    pss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (p_reg[48:0]),
        .den     (d_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_data.command == CMD_ADD) begin
                        state_next = ST_OUT;
                    end else if (cnt_reg != '0) begin
                        state_next = ST_A_RD;
                    end
                end
            end
            ST_A_RD:   state_next = ST_A_LD;
            ST_A_LD:   state_next = ST_B_CHK;
            ST_B_CHK: begin
                if (b_end) begin
                    state_next = ST_V_RD;
                end else if (!b_self) begin
                    state_next = ST_B_LD;
                end
            end
            ST_B_LD:   state_next = ST_SQ_X;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_SQ_ADD;
            ST_SQ_ADD: state_next = ST_SQ_GO;
            ST_SQ_GO:  state_next = ST_SQ_WT;
            ST_SQ_WT:  state_next = sqrt_done ? ST_FRC : ST_SQ_WT;
            ST_FRC:    state_next = ST_DV_GO;
            ST_DV_GO:  state_next = ST_DV_WT;
            ST_DV_WT:  state_next = div_done ? ST_F_X : ST_DV_WT;
            ST_F_X:    state_next = ST_F_Y;
            ST_F_Y:    state_next = ST_F_ACC;
            ST_F_ACC:  state_next = ST_B_CHK;
            ST_V_RD:   state_next = ST_V_M1;
            ST_V_M1:   state_next = ST_V_M2;
            ST_V_M2:   state_next = ST_V_M3;
            ST_V_M3:   state_next = ST_V_M4;
            ST_V_M4:   state_next = ST_V_M5;
            ST_V_M5:   state_next = a_last ? ST_P_RD : ST_A_RD;
            ST_P_RD:   state_next = ST_P_WR;
            ST_P_WR:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_fire) begin
                    state_next = m_data_reg.last ? ST_IDLE : ST_P_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rest_reg    <= REST_DISTANCE_RESET;
            damp_reg    <= DAMPING_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_REST_DISTANCE) begin
                    rest_reg <= cfg_data[11:0];
                end else if (cfg_index == REG_DAMPING) begin
                    damp_reg <= cfg_data;
                end
            end
            if (we_m) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if ((state_reg == ST_IDLE && in_fire && s_data.command == CMD_ADD) ||
                state_reg == ST_P_WR) begin
                m_valid_reg <= 1'b1;
            end else if (out_fire) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                a_reg <= '0;
                if (in_fire) begin
                    m_data_reg.dropped <= full;
                    m_data_reg.last    <= 1'b1;
                    if (full) begin
                        m_data_reg.slot  <= '0;
                        m_data_reg.out_x <= '0;
                        m_data_reg.out_y <= '0;
                    end else begin
                        m_data_reg.slot  <= 6'(cnt_reg);
                        m_data_reg.out_x <= s_data.new_x;
                        m_data_reg.out_y <= s_data.new_y;
                    end
                end
            end
            ST_A_LD: begin
                xa_reg <= rd_x_reg;
                ya_reg <= rd_y_reg;
                ma_reg <= rd_m_reg;
                ax_reg <= '0;
                ay_reg <= '0;
                b_reg  <= '0;
            end
            ST_B_CHK: begin
                if (!b_end && b_self) begin
                    b_reg <= b_reg + CNT_W'(1);
                end
            end
            ST_B_LD: begin
                dx_reg <= dxs;
                dy_reg <= dys;
                mb_reg <= rd_m_reg;
            end
            ST_SQ_Y:   sq_reg <= p_reg[62:0];
            ST_SQ_ADD: sq_reg <= sq_reg + p_reg[62:0];
            ST_SQ_WT: begin
                if (sqrt_done) begin
                    d_reg <= (sqrt_root < 32'd65536) ? 32'd65536 : sqrt_root;
                end
            end
            ST_DV_WT: begin
                if (div_done) begin
                    force_reg <= div_quot;
                end
            end
            ST_F_Y:    ax_reg <= ax_reg + term;
            ST_F_ACC: begin
                ay_reg <= ay_reg + term;
                b_reg  <= b_reg + CNT_W'(1);
            end
            ST_V_M2:   t_reg <= p_reg[49:0];
            ST_V_M4:   t_reg <= p_reg[49:0];
            ST_V_M5: begin
                a_reg <= a_last ? '0 : a_reg + CNT_W'(1);
            end
            ST_P_WR: begin
                m_data_reg.slot    <= 6'(a_reg);
                m_data_reg.out_x   <= new_x;
                m_data_reg.out_y   <= new_y;
                m_data_reg.dropped <= 1'b0;
                m_data_reg.last    <= a_last;
            end
            ST_OUT: begin
                if (out_fire) begin
                    a_reg <= a_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PARTICLES))
        else $error("particle count beyond store size");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken while a result is pending");

    a_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.dropped) |-> m_data.last)
        else $error("dropped beat not marked last");

    a_sqrt_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ_WT && sqrt_done) |=> state_reg == ST_FRC)
        else $error("square root result not consumed");
`endif

endmodule

`default_nettype wire

@@ rtl/core/pss_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Floor square root of a 64-bit value, one result bit per cycle.
module pss_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  step_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [35:0] rem_try;
    logic [35:0] trial;

    // Bring down two radicand bits and test the next root bit.
    assign rem_try = {rem_reg, rad_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == 5'd31) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            step_reg <= step_reg + 5'd1;
            if (rem_try >= trial) begin
                rem_reg  <= 34'(rem_try - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= rem_try[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ rtl/core/pss_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Signed 49-bit by unsigned 32-bit division, truncating toward zero.
// Restoring divider on magnitudes, one quotient bit per cycle.
module pss_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [48:0] num,
    input  wire logic        [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quot
);
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  step_reg;
    logic        neg_reg;
    logic [47:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [47:0] q_reg;
    logic [32:0] rem_try;
    logic [48:0] num_mag;

    assign num_mag = num[48] ? 49'(-num) : 49'(num);
    assign rem_try = {rem_reg, num_reg[47]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == 6'd47) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= num[48];
            num_reg  <= num_mag[47:0];
            den_reg  <= den;
            rem_reg  <= '0;
            q_reg    <= '0;
            step_reg <= '0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[46:0], 1'b0};
            step_reg <= step_reg + 6'd1;
            if (rem_try >= {1'b0, den_reg}) begin
                rem_reg <= 32'(rem_try - {1'b0, den_reg});
                q_reg   <= {q_reg[46:0], 1'b1};
            end else begin
                rem_reg <= rem_try[31:0];
                q_reg   <= {q_reg[46:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? 32'(-signed'(q_reg[31:0])) : signed'(q_reg[31:0]);

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import pss_pkg::*;

    localparam longint Q_ONE   = 65536;
    localparam longint S32_HI  = 64'sd2147483647;
    localparam longint S32_LO  = -64'sd2147483648;
    localparam logic [7:0] REG_UNUSED = 8'd5;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pss_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pss_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always #10 aclk = ~aclk;

    pairwise_spring_particle_step u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the particle store and the registers.
    int unsigned   sh_count;
    logic [11:0]   sh_rest;
    logic [15:0]   sh_damp;
    logic [15:0]   sh_mass [MAX_PARTICLES];
    longint        sh_px [MAX_PARTICLES];
    longint        sh_py [MAX_PARTICLES];
    longint        sh_vx [MAX_PARTICLES];
    longint        sh_vy [MAX_PARTICLES];

    pss_out_t      pending_beats[$];
    // Typed expectations, one entry per offered input beat, in order.
    bit            want_on_q[$];
    pss_out_t      want_q[$];
    bit            typed_on;
    pss_out_t      typed_want;
    int            fail_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_left = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint sat32(input longint v);
        if (v < S32_LO) return S32_LO;
        if (v > S32_HI) return S32_HI;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Work out the result beats of one accepted input beat and update the store.
    task automatic predict_particles(input pss_in_t it);
        pss_out_t beat;
        longint   nvx [MAX_PARTICLES];
        longint   nvy [MAX_PARTICLES];
        longint   rest_q, ax, ay, dx, dy, d, frc;
        longint unsigned mx, my;
        int n;
        n = sh_count;
        if (it.command == CMD_ADD) begin
            beat = '0;
            beat.last = 1'b1;
            if (n >= MAX_PARTICLES) begin
                beat.dropped = 1'b1;
            end else begin
                sh_mass[n] = it.new_mass;
                sh_px[n] = longint'(it.new_x);
                sh_py[n] = longint'(it.new_y);
                sh_vx[n] = 0;
                sh_vy[n] = 0;
                sh_count = n + 1;
                beat.slot = n[5:0];
                beat.out_x = it.new_x;
                beat.out_y = it.new_y;
            end
            pending_beats = {pending_beats, beat};
            return;
        end
        rest_q = longint'(sh_rest) * Q_ONE;
        for (int a = 0; a < n; a++) begin
            ax = 0;
            ay = 0;
            for (int b = 0; b < n; b++) begin
                if (a == b) continue;
                dx = sh_px[b] - sh_px[a];
                dy = sh_py[b] - sh_py[a];
                dx = (dx > S32_HI) ? S32_HI : (dx < -S32_HI) ? -S32_HI : dx;
                dy = (dy > S32_HI) ? S32_HI : (dy < -S32_HI) ? -S32_HI : dy;
                mx = (dx < 0) ? -dx : dx;
                my = (dy < 0) ? -dy : dy;
                d = longint'(int_sqrt(mx * mx + my * my));
                if (d < Q_ONE) d = Q_ONE;
                frc = ((d - rest_q) * longint'(sh_mass[b])) / d;
                ax += (frc * dx) >>> 16;
                ay += (frc * dy) >>> 16;
            end
            ax = sat32(ax);
            ay = sat32(ay);
            nvx[a] = sat32((longint'(sh_damp) * sh_vx[a] + ax * longint'(sh_mass[a])) >>> 16);
            nvy[a] = sat32((longint'(sh_damp) * sh_vy[a] + ay * longint'(sh_mass[a])) >>> 16);
        end
        for (int a = 0; a < n; a++) begin
            sh_vx[a] = nvx[a];
            sh_vy[a] = nvy[a];
            sh_px[a] = sat32(sh_px[a] + nvx[a]);
            sh_py[a] = sat32(sh_py[a] + nvy[a]);
            beat = '0;
            beat.slot = a[5:0];
            beat.out_x = sh_px[a][31:0];
            beat.out_y = sh_py[a][31:0];
            beat.last = (a + 1 == n);
            pending_beats = {pending_beats, beat};
        end
    endtask

    task automatic compare_beat(input pss_out_t got, input pss_out_t want, input string tag);
        if (got.slot !== want.slot) report_mismatch({tag, " slot"}, got.slot, want.slot);
        if (got.out_x !== want.out_x) report_mismatch({tag, " out_x"}, got.out_x, want.out_x);
        if (got.out_y !== want.out_y) report_mismatch({tag, " out_y"}, got.out_y, want.out_y);
        if (got.dropped !== want.dropped)
            report_mismatch({tag, " dropped"}, got.dropped, want.dropped);
        if (got.last !== want.last) report_mismatch({tag, " last"}, got.last, want.last);
    endtask

    // Observe every handshake: predict on input beats, check on result beats.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_REST_DISTANCE) sh_rest = cfg_data[11:0];
                else if (cfg_index == REG_DAMPING) sh_damp = cfg_data;
            end
            if (s_valid && s_ready) begin
                predict_particles(s_data);
                typed_on = want_on_q.pop_front();
                typed_want = want_q.pop_front();
                if (typed_on)
                    compare_beat(pending_beats[pending_beats.size() - 1], typed_want,
                                 "typed");
            end
            if (m_valid && m_ready) begin
                if (pending_beats.size() == 0) begin
                    report_mismatch("unexpected result beat slot", m_data.slot, -1);
                end else begin
                    compare_beat(m_data, pending_beats.pop_front(), "result");
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_checked(input pss_in_t it, input bit has_want, input pss_out_t want);
        want_on_q = {want_on_q, has_want};
        want_q = {want_q, want};
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_beat(input pss_in_t it);
        send_checked(it, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_beats.size() != 0) @(posedge aclk);
        // An empty step gives no result, so let it finish before going on.
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic pss_in_t make_add(input logic [31:0] x, input logic [31:0] y,
                                         input logic [15:0] m);
        pss_in_t it;
        it.command = CMD_ADD;
        it.new_x = x;
        it.new_y = y;
        it.new_mass = m;
        return it;
    endfunction

    function automatic pss_in_t make_step();
        pss_in_t it;
        it.command = CMD_STEP;
        it.new_x = $urandom;
        it.new_y = $urandom;
        it.new_mass = 16'($urandom);
        return it;
    endfunction

    // Random beat: an add or a step at random while the store is below the cap, steps otherwise.
    function automatic pss_in_t random_beat(input int cap);
        logic [31:0] x, y;
        if (sh_count < cap && $urandom_range(99) < 55) begin
            if ($urandom_range(9) == 0) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = $urandom_range(32'h07FF_FFFF) - 32'h0400_0000;
                y = $urandom_range(32'h07FF_FFFF) - 32'h0400_0000;
            end
            return make_add(x, y, 16'($urandom));
        end
        return make_step();
    endfunction

    // Directed stimulus: a beat or a register write, with an optional typed result.
    typedef struct {
        bit          is_reg;
        logic [7:0]  reg_idx;
        logic [15:0] reg_val;
        pss_in_t     beat;
        bit          has_want;
        pss_out_t    want;
    } stim_row_t;

    function automatic stim_row_t beat_row(input pss_in_t it, input bit has_want,
                                           input pss_out_t want);
        stim_row_t r;
        r.is_reg = 0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.beat = it;
        r.has_want = has_want;
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [7:0] idx, input logic [15:0] val);
        stim_row_t r;
        r.is_reg = 1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.beat = '0;
        r.has_want = 0;
        r.want = '0;
        return r;
    endfunction

    function automatic pss_out_t add_want(input int s, input logic [31:0] x,
                                          input logic [31:0] y);
        pss_out_t w;
        w.slot = s[5:0];
        w.out_x = x;
        w.out_y = y;
        w.dropped = 1'b0;
        w.last = 1'b1;
        return w;
    endfunction

    // Generous limit covering a full store and heavy stalling.
    initial begin
        #100ms;
        $display("timeout at %0t", $realtime);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        stim_row_t table_rows[$];
        pss_out_t  drop_want;
        pss_out_t  none;
        none = '0;
        drop_want = '0;
        drop_want.dropped = 1'b1;
        drop_want.last = 1'b1;
        sh_count = 0;
        sh_rest = REST_DISTANCE_RESET;
        sh_damp = DAMPING_RESET;

        // Empty step, extreme adds, coincident and saturating pairs, every register.
        table_rows = {table_rows, beat_row(make_step(), 0, none)};
        table_rows = {table_rows, beat_row(make_add(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF), 1,
                                           add_want(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF))};
        table_rows = {table_rows, beat_row(make_add(32'h8000_0000, 32'h8000_0000, 16'h0000), 1,
                                           add_want(1, 32'h8000_0000, 32'h8000_0000))};
        table_rows = {table_rows, beat_row(make_add(32'h0000_0000, 32'h0000_0000, 16'h0001), 1,
                                           add_want(2, 32'h0, 32'h0))};
        table_rows = {table_rows, beat_row(make_add(32'h0000_0000, 32'h0000_0000, 16'h8000), 1,
                                           add_want(3, 32'h0, 32'h0))};
        table_rows = {table_rows, beat_row(make_add(32'h0001_0000, 32'hFFFF_0000, 16'h5555), 1,
                                           add_want(4, 32'h0001_0000, 32'hFFFF_0000))};
        table_rows = {table_rows, beat_row(make_step(), 0, none)};
        table_rows = {table_rows, beat_row(make_step(), 0, none)};
        table_rows = {table_rows, reg_row(REG_REST_DISTANCE, 16'd0)};
        table_rows = {table_rows, beat_row(make_step(), 0, none)};
        table_rows = {table_rows, reg_row(REG_REST_DISTANCE, 16'd4095)};
        table_rows = {table_rows, reg_row(REG_DAMPING, 16'd0)};
        table_rows = {table_rows, beat_row(make_step(), 0, none)};
        table_rows = {table_rows, reg_row(REG_DAMPING, 16'hFFFF)};
        table_rows = {table_rows, reg_row(REG_UNUSED, 16'h1234)};
        table_rows = {table_rows, beat_row(make_step(), 0, none)};
        table_rows = {table_rows, reg_row(REG_REST_DISTANCE, 16'hFFFF)};
        table_rows = {table_rows, beat_row(make_step(), 0, none)};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_rows[i]) begin
            if (table_rows[i].is_reg) begin
                drain_results();
                write_reg(table_rows[i].reg_idx, table_rows[i].reg_val);
            end else begin
                send_checked(table_rows[i].beat, table_rows[i].has_want, table_rows[i].want);
            end
        end
        drain_results();

        // Random phases under each idling mode, fresh register settings each time.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3: begin send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin send_idle_pct = 0; recv_stall_pct = 20; end
            endcase
            write_reg(REG_REST_DISTANCE, 16'($urandom_range(600)));
            write_reg(REG_DAMPING, 16'($urandom));
            if (ph == 4) hold_left = 400;
            for (int k = 0; k < 6; k++) send_beat(random_beat(10));
            drain_results();
        end

        // Fill the store, overflow it, then one full-size step.
        send_idle_pct = 13;
        recv_stall_pct = 13;
        write_reg(REG_REST_DISTANCE, 16'd250);
        write_reg(REG_DAMPING, 16'd58982);
        hold_left = 300;
        repeat (MAX_PARTICLES) begin
            send_beat(make_add($urandom_range(32'h07FF_FFFF) - 32'h0400_0000,
                               $urandom_range(32'h07FF_FFFF) - 32'h0400_0000,
                               16'($urandom)));
        end
        for (int k = 0; k < 3; k++) begin
            send_checked(make_add($urandom, $urandom, 16'($urandom)), 1'b1, drop_want);
        end
        send_beat(make_step());
        drain_results();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
